>>> rtl/rsa_modexp_crypt_top_defines.svh
// assertion macros shared by the rsa_modexp_crypt rtl
// modules using them must have aclk and aresetn in scope
`ifndef RSA_MODEXP_CRYPT_TOP_DEFINES_SVH
`define RSA_MODEXP_CRYPT_TOP_DEFINES_SVH

// same-cycle implication
`define RSAME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSAME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rsame_pkg.sv
// shared constants and types for the rsa modular exponentiation block
// no dependencies
package rsame_pkg;

    localparam int DATA_BITS_DEF = 64;
    localparam int WORD_BITS     = 64;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PUB_EXP  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRIV_EXP = 2'd2;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // status of the modular multiplier toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

endpackage

>>> rtl/rsame_modmul.sv
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// depends on rsame_pkg and rsa_modexp_crypt_top_defines.svh
`include "rsa_modexp_crypt_top_defines.svh"
module rsame_modmul #(
    parameter int W = rsame_pkg::DATA_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [W-1:0]     op_a,
    input  logic [W-1:0]     op_b,
    input  logic [W-1:0]     modulus,
    output logic [W-1:0]     product,
    output rsame_pkg::mm_stat_t stat
);
    import rsame_pkg::*;

    localparam int CW = $clog2(W);
    localparam int TW = W + 2;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  acc_next;
    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  n_reg;

    logic [TW-1:0] sum;
    logic [TW-1:0] n1;
    logic [TW-1:0] n2;
    logic [TW-1:0] red;

    // 2*acc + bit*a stays below 3n, so at most two subtractions of n
    always_comb begin
        sum = {1'b0, acc_reg, 1'b0} + (b_reg[W-1] ? {2'b00, a_reg} : {TW{1'b0}});
        n1  = {2'b00, n_reg};
        n2  = {1'b0, n_reg, 1'b0};
        if (sum >= n2) begin
            red = sum - n2;
        end else if (sum >= n1) begin
            red = sum - n1;
        end else begin
            red = sum;
        end
        acc_next = red[W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            acc_reg <= '0;
            a_reg   <= op_a;
            b_reg   <= op_b;
            n_reg   <= modulus;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[W-2:0], 1'b0};
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `RSAME_ASSERT_NOW(a_acc_below_n, busy_reg, acc_reg < n_reg, "partial product not reduced")
    `RSAME_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "done raised while busy")
    `RSAME_ASSERT_NEXT(a_last_step, busy_reg && cnt_reg == '0, done_reg && !busy_reg,
        "last step did not finish the product")

endmodule

>>> rtl/rsa_modexp_crypt_top.sv
// a value not below the modulus is flagged as a range error without any multiplies;
// otherwise the bit-serial multiplier does the work, exponent bits taken msb first:
// one square per exponent bit, one multiply per set bit
// one item in flight; the next beat is taken while a finished result waits at the output
// synchronous active-low reset zeroes the key registers and returns control to idle
`include "rsa_modexp_crypt_top_defines.svh"
module rsa_modexp_crypt_top #(
    parameter int DATA_BITS = rsame_pkg::DATA_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [rsame_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [rsame_pkg::WORD_BITS-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_command,
    input  logic [rsame_pkg::WORD_BITS-1:0]     s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rsame_pkg::WORD_BITS-1:0]     m_result,
    output logic                                m_range_error
);
    import rsame_pkg::*;

    localparam int CW = $clog2(DATA_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_ML_GO,
        ST_ML_WAIT,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [DATA_BITS-1:0] mod_reg;
    logic [DATA_BITS-1:0] pub_reg;
    logic [DATA_BITS-1:0] priv_reg;
    logic [DATA_BITS-1:0] acc_reg;
    logic [DATA_BITS-1:0] base_reg;
    logic [DATA_BITS-1:0] exp_reg;
    logic [CW-1:0]        ecnt_reg;
    logic                 err_reg;
    logic                 m_valid_reg;
    logic [WORD_BITS-1:0] m_result_reg;
    logic                 m_err_reg;

    logic [DATA_BITS-1:0] in_value;
    logic                 mm_start;
    logic [DATA_BITS-1:0] mm_b;
    logic [DATA_BITS-1:0] mm_product;
    mm_stat_t             mm_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg  <= '0;
            pub_reg  <= '0;
            priv_reg <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_MODULUS:  mod_reg  <= cfg_wdata[DATA_BITS-1:0];
                CFG_PUB_EXP:  pub_reg  <= cfg_wdata[DATA_BITS-1:0];
                CFG_PRIV_EXP: priv_reg <= cfg_wdata[DATA_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign in_value = s_value[DATA_BITS-1:0];
    assign s_ready  = (state_reg == ST_IDLE);
    assign mm_start = (state_reg == ST_SQ_GO) || (state_reg == ST_ML_GO);
    assign mm_b     = (state_reg == ST_ML_GO) ? base_reg : acc_reg;

    rsame_modmul #(
        .W (DATA_BITS)
    ) u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .op_a    (acc_reg),
        .op_b    (mm_b),
        .modulus (mod_reg),
        .product (mm_product),
        .stat    (mm_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            err_reg     <= 1'b0;
            ecnt_reg    <= '0;
        end else begin
            // in the done state the output register is handled below
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        base_reg <= in_value;
                        exp_reg  <= (s_command == CMD_DECRYPT) ? priv_reg : pub_reg;
                        ecnt_reg <= CW'(DATA_BITS - 1);
                        if (in_value >= mod_reg) begin
                            err_reg   <= 1'b1;
                            acc_reg   <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            // 1 mod n, which is 0 for a modulus of one
                            err_reg   <= 1'b0;
                            acc_reg   <= (mod_reg == DATA_BITS'(1)) ? '0 : DATA_BITS'(1);
                            state_reg <= ST_SQ_GO;
                        end
                    end
                end
                ST_SQ_GO: state_reg <= ST_SQ_WAIT;
                ST_ML_GO: state_reg <= ST_ML_WAIT;
                ST_SQ_WAIT, ST_ML_WAIT: begin
                    if (mm_stat.done) begin
                        acc_reg <= mm_product;
                        if (state_reg == ST_SQ_WAIT && exp_reg[DATA_BITS-1]) begin
                            state_reg <= ST_ML_GO;
                        end else begin
                            exp_reg <= {exp_reg[DATA_BITS-2:0], 1'b0};
                            if (ecnt_reg == '0) begin
                                state_reg <= ST_DONE;
                            end else begin
                                ecnt_reg  <= ecnt_reg - 1'b1;
                                state_reg <= ST_SQ_GO;
                            end
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_result_reg <= WORD_BITS'(acc_reg);
                        m_err_reg    <= err_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result      = m_result_reg;
    assign m_range_error = m_err_reg;

    `RSAME_ASSERT_NOW(a_acc_reduced,
        state_reg == ST_SQ_GO || state_reg == ST_SQ_WAIT ||
        state_reg == ST_ML_GO || state_reg == ST_ML_WAIT,
        acc_reg < mod_reg, "accumulator not below modulus")
    `RSAME_ASSERT_NOW(a_start_free, mm_start, !mm_stat.busy, "multiplier started while busy")
    `RSAME_ASSERT_NOW(a_done_waited, mm_stat.done,
        state_reg == ST_SQ_WAIT || state_reg == ST_ML_WAIT, "product arrived unexpectedly")

endmodule

>>> bench/rsa_modexp_crypt_top_tb.sv
// self-checking bench for rsa_modexp_crypt_top: directed key/value corners, then random keys
// and words under sender idling and receiver stalls, scored against an in-bench modexp predictor
// depends on rsame_pkg and the rsa_modexp_crypt_top rtl
module rsa_modexp_crypt_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsame_pkg::*;

    // index with no register behind it, must be ignored
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam logic [63:0] WORD_MAX = '1;
    localparam logic [63:0] PRIME_64 = 64'hFFFF_FFFF_FFFF_FFC5;

    typedef struct packed {
        logic [63:0] result;
        logic        range_error;
    } crypt_beat_t;

    class crypt_scoreboard;
        logic [63:0] modulus;
        logic [63:0] pub_exp;
        logic [63:0] priv_exp;
        crypt_beat_t expected_q[$];
        int mismatches;
        int beats_in;
        int beats_checked;
        int range_errors;

        function new();
            modulus       = '0;
            pub_exp       = '0;
            priv_exp      = '0;
            mismatches    = 0;
            beats_in      = 0;
            beats_checked = 0;
            range_errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
            case (idx)
                CFG_MODULUS:  modulus  = data;
                CFG_PUB_EXP:  pub_exp  = data;
                CFG_PRIV_EXP: priv_exp = data;
                default: ;
            endcase
        endfunction

        function logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b);
            logic [127:0] prod;
            prod = {64'd0, a} * {64'd0, b};
            prod = prod % {64'd0, modulus};
            return prod[63:0];
        endfunction

        // left-to-right square and multiply, base already below the modulus
        function logic [63:0] pow_mod(logic [63:0] base, logic [63:0] power);
            logic [63:0] acc;
            acc = (modulus == 64'd1) ? 64'd0 : 64'd1;
            for (int i = 63; i >= 0; i--) begin
                acc = mul_mod(acc, acc);
                if (power[i])
                    acc = mul_mod(acc, base);
            end
            return acc;
        endfunction

        function void note_input(logic cmd, logic [63:0] value);
            crypt_beat_t beat;
            beats_in++;
            // a zero modulus puts every word out of range
            if (value >= modulus) begin
                beat.result      = '0;
                beat.range_error = 1'b1;
                range_errors++;
            end else begin
                beat.result      = pow_mod(value, (cmd == CMD_DECRYPT) ? priv_exp : pub_exp);
                beat.range_error = 1'b0;
            end
            expected_q.push_back(beat);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at %0t: %s", $time, msg);
        endfunction

        function void check_result(logic [63:0] result, logic range_error);
            crypt_beat_t want;
            beats_checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat %h/%b with nothing outstanding",
                                 result, range_error));
                return;
            end
            want = expected_q.pop_front();
            if (result !== want.result)
                report($sformatf("result: expected %h got %h", want.result, result));
            if (range_error !== want.range_error)
                report($sformatf("range_error: expected %b got %b",
                                 want.range_error, range_error));
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_wen;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [WORD_BITS-1:0]    cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_command;
    logic [WORD_BITS-1:0]    s_value;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [WORD_BITS-1:0]    m_result;
    logic                    m_range_error;

    crypt_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int key_settings   = 0;

    rsa_modexp_crypt_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result      (m_result),
        .m_range_error (m_range_error)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_command, s_value);
            if (m_valid && m_ready)
                sb.check_result(m_result, m_range_error);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
    endtask

    // all stimulus tasks start and end on a falling edge
    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] data);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    task automatic load_key(logic [63:0] n, logic [63:0] e, logic [63:0] d);
        cfg_write(CFG_MODULUS, n);
        cfg_write(CFG_PUB_EXP, e);
        cfg_write(CFG_PRIV_EXP, d);
        key_settings++;
    endtask

    task automatic send_word(logic cmd, logic [63:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            // junk payload while idle must be ignored
            s_valid   = 1'b0;
            s_command = 1'($urandom_range(1));
            s_value   = rand64();
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_command = cmd;
        s_value   = value;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic run_random_phase(int k, int count);
        logic [63:0] n;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] value;
        int r;
        case (k)
            0: begin n = rand64() | 64'h8000_0000_0000_0001; e = rand64(); d = rand64(); end
            1: begin
                n = (rand64() >> $urandom_range(62, 8)) | 64'd1;
                e = rand64();
                d = 64'd1 << $urandom_range(63);
            end
            2: begin n = rand64() | (64'd1 << 63); e = 64'd3; d = rand64(); end
            default: begin n = WORD_MAX; e = rand64(); d = 64'd65537; end
        endcase
        set_idling(k);
        load_key(n, e, d);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 85)
                value = rand64() % n;
            else if (r < 92)
                value = n;
            else
                value = rand64() | n;
            send_word(1'($urandom_range(1)), value);
            // hold off once until the block has drained completely
            if (k == 1 && i == count / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wen   = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_command = CMD_ENCRYPT;
        s_value   = '0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        set_idling(0);
        // registers still at reset: zero modulus rejects everything
        send_word(CMD_ENCRYPT, 64'd0);
        send_word(CMD_DECRYPT, WORD_MAX);
        wait_idle();

        load_key(64'd1, 64'd0, WORD_MAX);
        cfg_write(CFG_SPARE, rand64());
        send_word(CMD_ENCRYPT, 64'd0);
        send_word(CMD_DECRYPT, 64'd0);
        send_word(CMD_ENCRYPT, 64'd1);
        wait_idle();

        // zero public exponent, all-ones private exponent
        load_key(WORD_MAX, 64'd0, WORD_MAX);
        send_word(CMD_ENCRYPT, 64'd0);
        send_word(CMD_ENCRYPT, 64'd1);
        send_word(CMD_DECRYPT, WORD_MAX - 64'd1);
        send_word(CMD_DECRYPT, WORD_MAX);
        send_word(CMD_ENCRYPT, rand64() % WORD_MAX);
        wait_idle();

        set_idling(3);
        load_key(PRIME_64, 64'd65537, rand64());
        send_word(CMD_ENCRYPT, 64'd0);
        send_word(CMD_ENCRYPT, 64'd1);
        send_word(CMD_DECRYPT, 64'd2);
        send_word(CMD_ENCRYPT, PRIME_64 - 64'd1);
        send_word(CMD_DECRYPT, PRIME_64);
        send_word(CMD_ENCRYPT, 64'h8000_0000_0000_0000);
        wait_idle();

        load_key(64'd3, WORD_MAX, 64'd1);
        send_word(CMD_ENCRYPT, 64'd0);
        send_word(CMD_DECRYPT, 64'd1);
        send_word(CMD_ENCRYPT, 64'd2);
        send_word(CMD_DECRYPT, 64'd3);
        wait_idle();

        for (int k = 0; k < 4; k++)
            run_random_phase(k, 25);

        repeat (20) @(negedge aclk);
        $display("exercised %0d input beats over %0d key settings, %0d of them out of range",
                 sb.beats_in, key_settings, sb.range_errors);
        $display("checked %0d result beats, %0d field mismatches",
                 sb.beats_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // worst case is about 125 beats with every exponent bit set; allow several times that
    initial begin
        #60_000_000;
        $display("timeout with %0d results outstanding", sb.outstanding());
        $display("Mismatches found");
        $finish;
    end

endmodule
